### rtl/queued_beep_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the queued beep sequencer
// Both macros expect a clock named clock and a synchronous reset named reset.
// ----------------------------------------------------------------------------
`ifndef QUEUED_BEEP_SEQUENCER_ASSERT_SVH
`define QUEUED_BEEP_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBS_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("queued beep sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QBS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("queued beep sequencer: next-cycle check failed");

`endif

### rtl/qbs_pkg.sv
// ----------------------------------------------------------------------------
// Queued beep sequencer package
// Word types, codes and reset values shared by the sequencer modules.
// ----------------------------------------------------------------------------
package qbs_pkg;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_ENQUEUE = 1'b1;

   localparam logic CSR_GAP_TICKS  = 1'b0;
   localparam logic CSR_HOLD_TICKS = 1'b1;

   localparam logic [15:0] GAP_TICKS_RESET  = 16'd50;
   localparam logic [15:0] HOLD_TICKS_RESET = 16'd1000;
   localparam logic [15:0] TICK_MAX         = 16'hFFFF;
   localparam logic [2:0]  PENDING_MAX      = 3'd7;

   typedef struct packed {
      logic        op;
      logic [15:0] beep_ticks;
      logic        hold_after;
   } req_type;

   typedef struct packed {
      logic       buzzer_on;
      logic       busy_res;
      logic       accepted;
      logic [2:0] pending;
   } rsp_type;

   typedef struct packed {
      logic        hold_after;
      logic [15:0] beep_ticks;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SOUND = 4'b0010,
      PH_GAP   = 4'b0100,
      PH_HOLD  = 4'b1000
   } phase_type;

endpackage

### rtl/queued_beep_sequencer.sv
// ----------------------------------------------------------------------------
// Queued beep sequencer
// Buzzer beep player fed by a small queue of beep requests.
// ----------------------------------------------------------------------------
// A word is offered on req_word with start; it is taken at a clock edge where
// start is high and busy is low. busy is high only during reset, so one word
// may be taken in every cycle. An enqueue word stores a beep unless the queue
// holds QUEUE_DEPTH-1 beeps; a tick word advances the tick counter and the
// idle, sounding, gap and hold phases.
// Each word gives exactly one result word on rsp_word, marked by rsp_valid
// for one cycle, in the cycle after the word is taken, with one word per
// cycle of throughput, set by the single register stage of the phase
// machine and the queue cells. The receiver cannot stall the result.
// The csr channel writes gap_ticks (index 0) and hold_ticks (index 1); it is
// always ready and must be used only while no word is in flight.
// Reset clears the queue count, the phase machine and the result strobe,
// and restores gap_ticks to 50 and hold_ticks to 1000.
// ----------------------------------------------------------------------------
`include "queued_beep_sequencer_assert.svh"

module queued_beep_sequencer #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qbs_pkg::req_type req_word,
   output logic             rsp_valid,
   output qbs_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH);

   qbs_pkg::phase_type phase_ff;
   qbs_pkg::phase_type phase_in;
   logic [15:0]        tick_ff;
   logic [15:0]        tick_in;
   logic [15:0]        tick_inc;
   logic [15:0]        length_ff;
   logic [15:0]        length_in;
   logic               hold_flag_ff;
   logic               hold_flag_in;
   logic               buzzer_ff;
   logic               buzzer_in;
   logic               busy_flag_ff;
   logic               busy_flag_in;
   logic [15:0]        gap_ff;
   logic [15:0]        hold_ticks_ff;
   logic               rsp_valid_ff;
   qbs_pkg::rsp_type   rsp_word_ff;
   qbs_pkg::rsp_type   rsp_word_in;

   logic               req_accept;
   logic               tick;
   logic               pop;
   logic               flush;
   logic               push_ok;
   logic               empty;
   qbs_pkg::entry_type head;
   qbs_pkg::entry_type push_entry;
   logic [CW-1:0]      count_next;

   assign busy       = reset;
   assign csr_ready  = 1'b1;
   assign req_accept = start && !busy;
   assign tick       = req_accept && (req_word.op == qbs_pkg::OP_TICK);

   assign push_entry.hold_after = req_word.hold_after;
   assign push_entry.beep_ticks = req_word.beep_ticks;

   assign tick_inc = (tick_ff != qbs_pkg::TICK_MAX) ? tick_ff + 16'd1 : tick_ff;

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      length_in    = length_ff;
      hold_flag_in = hold_flag_ff;
      buzzer_in    = buzzer_ff;
      busy_flag_in = busy_flag_ff;
      pop          = 1'b0;
      flush        = 1'b0;
      if (tick) begin
         tick_in = tick_inc;
         case (phase_ff)
            qbs_pkg::PH_IDLE: begin
               if (!empty) begin
                  pop          = 1'b1;
                  length_in    = head.beep_ticks;
                  hold_flag_in = head.hold_after;
                  buzzer_in    = 1'b1;
                  tick_in      = '0;
                  busy_flag_in = 1'b1;
                  phase_in     = qbs_pkg::PH_SOUND;
               end
            end
            qbs_pkg::PH_SOUND: begin
               if (tick_inc >= length_ff) begin
                  tick_in   = '0;
                  buzzer_in = 1'b0;
                  phase_in  = qbs_pkg::PH_GAP;
               end
            end
            qbs_pkg::PH_GAP: begin
               if (tick_inc >= gap_ff) begin
                  tick_in  = '0;
                  phase_in = hold_flag_ff ? qbs_pkg::PH_HOLD : qbs_pkg::PH_IDLE;
               end
            end
            qbs_pkg::PH_HOLD: begin
               if (tick_inc >= hold_ticks_ff) begin
                  tick_in      = '0;
                  flush        = 1'b1;
                  busy_flag_in = 1'b0;
                  phase_in     = qbs_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = qbs_pkg::PH_IDLE;
            end
         endcase
      end
   end

   qbs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept && (req_word.op == qbs_pkg::OP_ENQUEUE)),
      .push_entry (push_entry),
      .pop        (pop),
      .flush      (flush),
      .push_ok    (push_ok),
      .empty      (empty),
      .head       (head),
      .count_next (count_next)
   );

   always_comb begin
      rsp_word_in.buzzer_on = buzzer_in;
      rsp_word_in.busy_res  = busy_flag_in;
      rsp_word_in.accepted  = push_ok;
      rsp_word_in.pending   = (32'(count_next) > 32'(qbs_pkg::PENDING_MAX)) ?
                              qbs_pkg::PENDING_MAX : 3'(count_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= qbs_pkg::PH_IDLE;
         tick_ff       <= '0;
         length_ff     <= '0;
         hold_flag_ff  <= 1'b0;
         buzzer_ff     <= 1'b0;
         busy_flag_ff  <= 1'b0;
         gap_ff        <= qbs_pkg::GAP_TICKS_RESET;
         hold_ticks_ff <= qbs_pkg::HOLD_TICKS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         length_ff    <= length_in;
         hold_flag_ff <= hold_flag_in;
         buzzer_ff    <= buzzer_in;
         busy_flag_ff <= busy_flag_in;
         rsp_valid_ff <= req_accept;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               qbs_pkg::CSR_GAP_TICKS: begin
                  gap_ff <= csr_wdata;
               end
               qbs_pkg::CSR_HOLD_TICKS: begin
                  hold_ticks_ff <= csr_wdata;
               end
               default: begin
                  gap_ff <= gap_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `QBS_ASSERT_NEXT(a_rsp_follows_word, 1'b1, rsp_valid == $past(req_accept))
   `QBS_ASSERT_SAME(a_sound_while_busy, phase_ff == qbs_pkg::PH_SOUND, busy_flag_ff && buzzer_ff)
   `QBS_ASSERT_NEXT(a_tick_not_stored, tick, !rsp_word.accepted)

endmodule

### rtl/qbs_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queued beep; shifts in its neighbour's entry on a pop or loads
// a new entry when it is the first free cell.
// ----------------------------------------------------------------------------
module qbs_cell (
   input  logic                  clock,
   input  qbs_pkg::cell_ctrl_type ctrl,
   input  qbs_pkg::entry_type    load_entry,
   input  qbs_pkg::entry_type    next_entry,
   output qbs_pkg::entry_type    entry
);

   qbs_pkg::entry_type entry_ff;
   qbs_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = next_entry;
      end else if (ctrl.load) begin
         entry_in = load_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/qbs_queue.sv
// ----------------------------------------------------------------------------
// Beep queue
// A row of cells with a fill count; the head sits in the first cell.
// ----------------------------------------------------------------------------
`include "queued_beep_sequencer_assert.svh"

module qbs_queue #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  qbs_pkg::entry_type           push_entry,
   input  logic                         pop,
   input  logic                         flush,
   output logic                         push_ok,
   output logic                         empty,
   output qbs_pkg::entry_type           head,
   output logic [$clog2(QUEUE_DEPTH)-1:0] count_next
);

   localparam int CAP = QUEUE_DEPTH - 1;
   localparam int CW  = $clog2(QUEUE_DEPTH);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          full;

   qbs_pkg::entry_type entries [CAP];

   assign full    = (count_ff == CW'(CAP));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;

   always_comb begin
      count_in = count_ff;
      if (flush) begin
         count_in = '0;
      end else if (pop && !empty) begin
         count_in = count_ff - 1'b1;
      end else if (push_ok) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      qbs_pkg::cell_ctrl_type ctrl;
      qbs_pkg::entry_type     next_entry;

      assign ctrl.shift = pop && !empty;
      assign ctrl.load  = push_ok && (count_ff == CW'(i));

      if (i == CAP - 1) begin : g_tail
         assign next_entry = entries[i];
      end else begin : g_body
         assign next_entry = entries[i+1];
      end

      qbs_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_entry (push_entry),
         .next_entry (next_entry),
         .entry      (entries[i])
      );
   end

   assign head       = entries[0];
   assign count_next = count_in;

   `QBS_ASSERT_SAME(a_count_in_range, 1'b1, count_ff <= CW'(CAP))
   `QBS_ASSERT_NEXT(a_push_fills, push_ok && !flush && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

### sim/tb_queued_beep_sequencer.sv
// ----------------------------------------------------------------------------
// Testbench for the queued beep sequencer
// A table of directed words is followed by random alerts and noise under
// several gap and hold settings. Every result word is checked field by field
// against the bench's own queue and phase predictor or an exact table row.
// ----------------------------------------------------------------------------
module tb_queued_beep_sequencer;

   localparam int QDEPTH = 5;

   typedef struct packed {
      qbs_pkg::req_type w;
      logic             exact;
      qbs_pkg::rsp_type want;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   qbs_pkg::req_type req_word = '0;
   logic             rsp_valid;
   qbs_pkg::rsp_type rsp_word;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = qbs_pkg::CSR_GAP_TICKS;
   logic [15:0]      csr_wdata = '0;

   logic             word_exact = 1'b0;
   qbs_pkg::rsp_type word_want = '0;

   qbs_pkg::entry_type beep_queue [QDEPTH];
   int unsigned        q_rd;
   int unsigned        q_wr;
   qbs_pkg::phase_type seq_phase;
   logic [15:0]        seq_ticks;
   logic [15:0]        seq_len;
   logic               seq_hold_flag;
   logic               seq_buzz;
   logic               seq_busy;
   logic [15:0]        gap_setting;
   logic [15:0]        hold_setting;

   qbs_pkg::rsp_type rsp_due [$];
   dir_row_type      dir_tab [$];

   int errors = 0;
   int words_taken = 0;
   int words_checked = 0;
   int drops = 0;
   int releases = 0;
   int sent = 0;
   bit calm = 1'b0;
   int cur_gap = 0;
   int cur_hold = 0;

   queued_beep_sequencer #(.QUEUE_DEPTH(QDEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
      $display("mismatch at result %0d: %s expected %0d got %0d",
               words_checked, what, exp_v, got_v);
      errors++;
   endtask

   task automatic check_field(input string what, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         flag_mismatch(what, exp_v, got_v);
      end
   endtask

   function automatic qbs_pkg::rsp_type advance_sequencer(input qbs_pkg::req_type w);
      qbs_pkg::rsp_type r;
      int unsigned      nxt;
      int unsigned      cnt;
      r = '0;
      if (w.op == qbs_pkg::OP_ENQUEUE) begin
         nxt = (q_wr + 1) % QDEPTH;
         if (nxt != q_rd) begin
            beep_queue[q_wr].beep_ticks = w.beep_ticks;
            beep_queue[q_wr].hold_after = w.hold_after;
            q_wr = nxt;
            r.accepted = 1'b1;
         end else begin
            drops++;
         end
      end else begin
         if (seq_ticks != qbs_pkg::TICK_MAX) seq_ticks = seq_ticks + 16'd1;
         case (seq_phase)
            qbs_pkg::PH_IDLE: begin
               if (q_rd != q_wr) begin
                  seq_len = beep_queue[q_rd].beep_ticks;
                  seq_hold_flag = beep_queue[q_rd].hold_after;
                  q_rd = (q_rd + 1) % QDEPTH;
                  seq_buzz = 1'b1;
                  seq_ticks = '0;
                  seq_busy = 1'b1;
                  seq_phase = qbs_pkg::PH_SOUND;
               end
            end
            qbs_pkg::PH_SOUND: begin
               if (seq_ticks >= seq_len) begin
                  seq_ticks = '0;
                  seq_buzz = 1'b0;
                  seq_phase = qbs_pkg::PH_GAP;
               end
            end
            qbs_pkg::PH_GAP: begin
               if (seq_ticks >= gap_setting) begin
                  seq_ticks = '0;
                  seq_phase = seq_hold_flag ? qbs_pkg::PH_HOLD : qbs_pkg::PH_IDLE;
               end
            end
            qbs_pkg::PH_HOLD: begin
               if (seq_ticks >= hold_setting) begin
                  seq_ticks = '0;
                  q_rd = 0;
                  q_wr = 0;
                  seq_busy = 1'b0;
                  seq_phase = qbs_pkg::PH_IDLE;
                  releases++;
               end
            end
            default: begin
               seq_phase = qbs_pkg::PH_IDLE;
            end
         endcase
      end
      cnt = (q_wr + QDEPTH - q_rd) % QDEPTH;
      r.pending = (cnt > qbs_pkg::PENDING_MAX) ? qbs_pkg::PENDING_MAX : cnt[2:0];
      r.buzzer_on = seq_buzz;
      r.busy_res = seq_busy;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      qbs_pkg::rsp_type pred;
      qbs_pkg::rsp_type due;
      if (reset) begin
         foreach (beep_queue[i]) beep_queue[i] = '0;
         q_rd = 0;
         q_wr = 0;
         seq_phase = qbs_pkg::PH_IDLE;
         seq_ticks = '0;
         seq_len = '0;
         seq_hold_flag = 1'b0;
         seq_buzz = 1'b0;
         seq_busy = 1'b0;
         gap_setting = qbs_pkg::GAP_TICKS_RESET;
         hold_setting = qbs_pkg::HOLD_TICKS_RESET;
         rsp_due.delete();
      end else begin
         if (rsp_valid) begin
            if (rsp_due.size() == 0) begin
               flag_mismatch("result words with nothing outstanding", 0, 1);
            end else begin
               due = rsp_due.pop_front();
               check_field("buzzer_on", int'(due.buzzer_on), int'(rsp_word.buzzer_on));
               check_field("busy_res", int'(due.busy_res), int'(rsp_word.busy_res));
               check_field("accepted", int'(due.accepted), int'(rsp_word.accepted));
               check_field("pending", int'(due.pending), int'(rsp_word.pending));
               words_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               qbs_pkg::CSR_GAP_TICKS:  gap_setting = csr_wdata;
               qbs_pkg::CSR_HOLD_TICKS: hold_setting = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            pred = advance_sequencer(req_word);
            rsp_due.push_back(word_exact ? word_want : pred);
            words_taken++;
         end
      end
   end

   task automatic send_word(input qbs_pkg::req_type w, input logic exact,
                            input qbs_pkg::rsp_type want);
      int gap_len;
      start <= 1'b1;
      req_word <= w;
      word_exact <= exact;
      word_want <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap_len = $urandom_range(1, 14);
         start <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   task automatic send_tick();
      qbs_pkg::req_type w;
      w.op = qbs_pkg::OP_TICK;
      w.beep_ticks = 16'($urandom_range(0, 65535));
      w.hold_after = 1'($urandom_range(0, 1));
      send_word(w, 1'b0, '0);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_timing(input logic [15:0] gap, input logic [15:0] hold);
      csr_valid <= 1'b1;
      csr_index <= qbs_pkg::CSR_GAP_TICKS;
      csr_wdata <= gap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= qbs_pkg::CSR_HOLD_TICKS;
      csr_wdata <= hold;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_gap = int'(gap);
      cur_hold = int'(hold);
   endtask

   // Beeps queued behind a hold beep are flushed when the hold ends, so the
   // long random durations are only ever queued there.
   task automatic run_alert(input int nbeeps, input bit with_hold, input bit short_ok);
      int               budget;
      int               d;
      int               n_ticks;
      qbs_pkg::req_type w;
      budget = with_hold ? ((cur_hold == 0) ? 1 : cur_hold) : 0;
      for (int i = 0; i < nbeeps; i++) begin
         d = $urandom_range(0, 6);
         budget += 1 + ((d == 0) ? 1 : d) + ((cur_gap == 0) ? 1 : cur_gap);
         w.op = qbs_pkg::OP_ENQUEUE;
         w.beep_ticks = 16'(d);
         w.hold_after = (i == nbeeps - 1) ? with_hold : ($urandom_range(0, 9) == 0);
         send_word(w, 1'b0, '0);
         if (i != nbeeps - 1 && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) send_tick();
         end
      end
      if (with_hold) begin
         repeat ($urandom_range(0, 2)) begin
            w.op = qbs_pkg::OP_ENQUEUE;
            w.beep_ticks = 16'($urandom_range(0, 65535));
            w.hold_after = 1'($urandom_range(0, 1));
            send_word(w, 1'b0, '0);
         end
      end
      if (short_ok && $urandom_range(0, 6) == 0) n_ticks = $urandom_range(0, budget);
      else n_ticks = budget + $urandom_range(0, 3);
      repeat (n_ticks) send_tick();
   endtask

   task automatic run_phase(input logic [15:0] gap, input logic [15:0] hold, input int words);
      int               goal;
      qbs_pkg::req_type w;
      settle();
      set_timing(gap, hold);
      goal = sent + words;
      while (sent < goal) begin
         if ($urandom_range(0, 4) != 0) begin
            run_alert($urandom_range(1, 5), $urandom_range(0, 3) != 0, 1'b1);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               w.op = 1'($urandom_range(0, 1));
               w.beep_ticks = 16'($urandom_range(0, 20));
               w.hold_after = 1'($urandom_range(0, 1));
               send_word(w, 1'b0, '0);
            end
         end
      end
   endtask

   function automatic dir_row_type row_chk(input logic op, input logic [15:0] ticks,
                                           input logic hold);
      row_chk = '0;
      row_chk.w = {op, ticks, hold};
   endfunction

   function automatic dir_row_type row_is(input logic op, input logic [15:0] ticks,
                                          input logic hold, input qbs_pkg::rsp_type want);
      row_is = '0;
      row_is.w = {op, ticks, hold};
      row_is.exact = 1'b1;
      row_is.want = want;
   endfunction

   initial begin : stimulus
      qbs_pkg::req_type long_beep;
      // With zero gap and hold: fill the queue, refuse one word, play a hold
      // beep, then an alert of two beeps that ends in a release.
      dir_tab.push_back(row_is(qbs_pkg::OP_TICK, 16'hFFFF, 1'b1,
                               {1'b0, 1'b0, 1'b0, 3'd0}));
      dir_tab.push_back(row_is(qbs_pkg::OP_ENQUEUE, 16'h0000, 1'b1,
                               {1'b0, 1'b0, 1'b1, 3'd1}));
      dir_tab.push_back(row_is(qbs_pkg::OP_ENQUEUE, 16'hFFFF, 1'b0,
                               {1'b0, 1'b0, 1'b1, 3'd2}));
      dir_tab.push_back(row_is(qbs_pkg::OP_ENQUEUE, 16'h5555, 1'b1,
                               {1'b0, 1'b0, 1'b1, 3'd3}));
      dir_tab.push_back(row_is(qbs_pkg::OP_ENQUEUE, 16'hAAAA, 1'b0,
                               {1'b0, 1'b0, 1'b1, 3'd4}));
      dir_tab.push_back(row_is(qbs_pkg::OP_ENQUEUE, 16'h0003, 1'b1,
                               {1'b0, 1'b0, 1'b0, 3'd4}));
      dir_tab.push_back(row_chk(qbs_pkg::OP_TICK, 16'h0000, 1'b0));
      dir_tab.push_back(row_chk(qbs_pkg::OP_ENQUEUE, 16'h0007, 1'b0));
      dir_tab.push_back(row_chk(qbs_pkg::OP_TICK, 16'h1234, 1'b1));
      dir_tab.push_back(row_chk(qbs_pkg::OP_TICK, 16'h0000, 1'b0));
      dir_tab.push_back(row_is(qbs_pkg::OP_TICK, 16'h0000, 1'b0,
                               {1'b0, 1'b0, 1'b0, 3'd0}));
      dir_tab.push_back(row_chk(qbs_pkg::OP_ENQUEUE, 16'h0002, 1'b0));
      dir_tab.push_back(row_chk(qbs_pkg::OP_ENQUEUE, 16'h0001, 1'b1));
      repeat (7) dir_tab.push_back(row_chk(qbs_pkg::OP_TICK, 16'h0000, 1'b0));
      dir_tab.push_back(row_is(qbs_pkg::OP_TICK, 16'h0000, 1'b0,
                               {1'b0, 1'b0, 1'b0, 3'd0}));
      dir_tab.push_back(row_chk(qbs_pkg::OP_TICK, 16'hFFFF, 1'b1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_timing(16'd0, 16'd0);
      foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].exact, dir_tab[i].want);

      run_phase(16'd1, 16'd2, 375);
      run_phase(16'd0, 16'd3, 375);
      run_phase(16'd4, 16'd0, 375);
      run_phase(16'($urandom_range(0, 6)), 16'($urandom_range(0, 9)), 375);

      settle();
      set_timing(16'hFFFF, 16'hFFFF);
      long_beep.op = qbs_pkg::OP_ENQUEUE;
      long_beep.beep_ticks = 16'd3;
      long_beep.hold_after = 1'b1;
      send_word(long_beep, 1'b0, '0);
      repeat (60) send_tick();

      calm = 1'b1;
      run_phase(16'd2, 16'd1, 200);
      settle();

      $display("Ran %0d words through seven gap and hold settings, %0d results checked.",
               words_taken, words_checked);
      $display("Saw %0d enqueues refused on a full queue and %0d alerts released.",
               drops, releases);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
